@@ design/utss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package utss_pkg;

	// longest well-formed sequence, in bytes
	localparam int unsigned RUN_MAX = 4;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MIN   = 8'hC2;
	localparam logic [7:0] LEAD2_MAX   = 8'hDF;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD3_MAX   = 8'hEF;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD4_MAX   = 8'hF4;
	localparam logic [1:0] CONT_TAG    = 2'b10;

	localparam logic [2:0] LEN_BAD  = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THR  = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// a finished run of bytes, first byte in lane 0
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [1:0]              last_idx;
	} run_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_BAD;
		if (b < ASCII_LIMIT) begin
			len = LEN_ONE;
		end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
			len = LEN_TWO;
		end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
			len = LEN_THR;
		end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
			len = LEN_FOUR;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

@@ design/utss_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utss_front
	import utss_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	input  wire logic       run_full,
	output logic            run_push,
	output run_t            run_data
);

	logic [7:0] held_q [3];
	logic [1:0] held_count_q;
	logic [2:0] needed_length_q;

	logic [1:0] held_count_d;
	logic [2:0] needed_length_d;
	logic       held_wr;
	logic [1:0] held_wr_idx;
	logic       emit;
	logic       accept;
	logic       is_cont;
	logic [2:0] lead;

	assign data_ready = !run_full;
	assign accept     = data_valid && data_ready;
	assign is_cont    = (data_byte[7:6] == CONT_TAG);
	assign lead       = lead_len(data_byte);
	assign run_push   = accept && emit;

	always_comb begin
		held_count_d    = held_count_q;
		needed_length_d = needed_length_q;
		held_wr         = 1'b0;
		held_wr_idx     = held_count_q;
		emit            = 1'b0;
		run_data.bytes[0] = (held_count_q > 2'd0) ? held_q[0] : data_byte;
		run_data.bytes[1] = (held_count_q > 2'd1) ? held_q[1] : data_byte;
		run_data.bytes[2] = (held_count_q > 2'd2) ? held_q[2] : data_byte;
		run_data.bytes[3] = data_byte;
		run_data.last_idx = held_count_q;

		if (is_cont) begin
			// orphan continuation falls through with no change
			if (needed_length_q != 3'd0 && held_count_q != 2'd0) begin
				if ({1'b0, held_count_q} + 3'd1 == needed_length_q) begin
					emit            = 1'b1;
					held_count_d    = 2'd0;
					needed_length_d = 3'd0;
				end else if (held_count_q != 2'd3) begin
					held_wr      = 1'b1;
					held_count_d = held_count_q + 2'd1;
				end else begin
					held_count_d    = 2'd0;
					needed_length_d = 3'd0;
				end
			end
		end else begin
			held_count_d    = 2'd0;
			needed_length_d = 3'd0;
			if (lead == LEN_ONE) begin
				emit              = 1'b1;
				run_data.bytes    = {RUN_MAX{data_byte}};
				run_data.last_idx = 2'd0;
			end else if (lead != LEN_BAD) begin
				held_wr         = 1'b1;
				held_wr_idx     = 2'd0;
				held_count_d    = 2'd1;
				needed_length_d = lead;
			end
		end

		if (end_of_stream) begin
			held_count_d    = 2'd0;
			needed_length_d = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q    <= 2'd0;
			needed_length_q <= 3'd0;
		end else if (accept) begin
			held_count_q    <= held_count_d;
			needed_length_q <= needed_length_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_wr) begin
			held_q[held_wr_idx] <= data_byte;
		end
	end

	// an open sequence always holds at least its lead and fewer bytes than it needs
	a_open_has_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(needed_length_q != 3'd0) |-> (held_count_q != 2'd0
			&& {1'b0, held_count_q} < needed_length_q))
		else $error("open sequence with bad held count");

	a_idle_holds_none: assert property (@(posedge clk) disable iff (!arst_n)
		(needed_length_q == 3'd0) |-> (held_count_q == 2'd0))
		else $error("bytes held with no open sequence");

	a_no_len_one: assert property (@(posedge clk) disable iff (!arst_n)
		needed_length_q != LEN_ONE)
		else $error("single-byte length left open");

endmodule

`default_nettype wire

@@ design/utss_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utss_fifo
	import utss_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  run_t      push_data,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output run_t      head_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	run_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full run queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty run queue");

endmodule

`default_nettype wire

@@ design/utss_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utss_back
	import utss_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  run_t            head_data,
	output logic            pop,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	logic                    run_valid_q;
	logic [RUN_MAX-1:0][7:0] run_bytes_q;
	logic [1:0]              run_left_q;
	logic                    out_load;
	logic                    run_done;

	assign out_load = run_valid_q && (!result_valid || result_ready);
	assign run_done = out_load && (run_left_q == 2'd0);
	// refill the run register in the same cycle its last word leaves
	assign pop      = head_valid && (!run_valid_q || run_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q  <= 1'b0;
			run_left_q   <= 2'd0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				run_valid_q <= 1'b1;
				run_left_q  <= head_data.last_idx;
			end else if (run_done) begin
				run_valid_q <= 1'b0;
			end else if (out_load) begin
				run_left_q <= run_left_q - 2'd1;
			end

			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			run_bytes_q <= head_data.bytes;
		end else if (out_load) begin
			run_bytes_q <= {8'h00, run_bytes_q[RUN_MAX-1:1]};
		end
		if (out_load) begin
			out_byte    <= run_bytes_q[0];
			last_of_run <= (run_left_q == 2'd0);
		end
	end

	a_idle_takes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!run_valid_q && head_valid) |=> run_valid_q)
		else $error("waiting run not picked up");

endmodule

`default_nettype wire

@@ design/utf8_stream_sanitizer.sv @@
// utf8_stream_sanitizer: passes only complete UTF-8 sequences from a byte stream.
// Input channel data_valid/data_ready carries one word per item: data_byte and
// end_of_stream (drop any partial sequence once this byte is handled).
// Output channel result_valid/result_ready carries one word per emitted byte:
// out_byte and last_of_run, set on the final word produced by one input word.
// ASCII goes out alone; a 2- to 4-byte sequence is held until complete and then
// goes out as one run. Bad leads, orphan continuations and interrupted or
// unfinished sequences are dropped without output.
// Throughput: one input word per cycle while the run queue has room and one
// output word per cycle while the receiver is ready, runs streamed back to
// back from the run register.
// Path: a run completed by an input word is written to the run queue at the
// accepting edge, then goes through the run register and the output register.
// When the receiver stalls the run queue fills; data_ready falls once
// FIFO_DEPTH finished runs are waiting. Words that only extend a sequence are
// still taken while the queue has room.
// Reset clears the held sequence, the run queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_sanitizer
	import utss_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	run_t run_in;
	run_t run_head;
	logic run_push;
	logic run_full;
	logic run_pop;
	logic run_avail;

	utss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.run_full      (run_full),
		.run_push      (run_push),
		.run_data      (run_in)
	);

	utss_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (run_push),
		.push_data  (run_in),
		.full       (run_full),
		.pop        (run_pop),
		.head_valid (run_avail),
		.head_data  (run_head)
	);

	utss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (run_avail),
		.head_data    (run_head),
		.pop          (run_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

@@ verif/tb_utf8_stream_sanitizer.sv @@
`timescale 1ns / 1ps

module tb_utf8_stream_sanitizer;
	import utss_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 500;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [7:0] value;
		logic       last_flag;
	} sanitized_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_ready;
	logic [7:0] data_byte = '0;
	logic       end_of_stream = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	// sequence being collected by the predictor
	logic [7:0] held_seq [3];
	logic [1:0] held_n = '0;
	logic [2:0] want_len = LEN_BAD;

	sanitized_byte_t expected_bytes [$];
	int unsigned     errors = 0;
	int unsigned     words_sent = 0;
	int unsigned     quiet_cycles = 0;
	int unsigned     stall_left = 0;
	bit              calm = 1'b0;

	utf8_stream_sanitizer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [2:0] sequence_length(input logic [7:0] b);
		if (b < ASCII_LIMIT) return LEN_ONE;
		if (b >= LEAD2_MIN && b <= LEAD2_MAX) return LEN_TWO;
		if (b >= LEAD3_MIN && b <= LEAD3_MAX) return LEN_THR;
		if (b >= LEAD4_MIN && b <= LEAD4_MAX) return LEN_FOUR;
		return LEN_BAD;
	endfunction

	function automatic void sanitize_word(input logic [7:0] b, input logic eos);
		logic [7:0] run [$];
		logic [2:0] len;
		if (b[7:6] == CONT_TAG) begin
			// continuation with nothing open is an orphan and vanishes
			if (want_len != LEN_BAD && held_n != 2'd0) begin
				if (held_n + 3'd1 == want_len) begin
					for (int k = 0; k < held_n; k++)
						run.push_back(held_seq[k]);
					run.push_back(b);
					held_n = '0;
					want_len = LEN_BAD;
				end else if (held_n != 2'd3) begin
					held_seq[held_n] = b;
					held_n++;
				end else begin
					held_n = '0;
					want_len = LEN_BAD;
				end
			end
		end else begin
			len = sequence_length(b);
			held_n = '0;
			want_len = LEN_BAD;
			if (len == LEN_ONE) begin
				run.push_back(b);
			end else if (len != LEN_BAD) begin
				held_seq[0] = b;
				held_n = 2'd1;
				want_len = len;
			end
		end
		if (eos) begin
			held_n = '0;
			want_len = LEN_BAD;
		end
		foreach (run[k])
			expected_bytes.push_back('{value: run[k], last_flag: (k == run.size() - 1)});
	endfunction

	task automatic check_result();
		sanitized_byte_t want;
		if (expected_bytes.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected word out_byte=%h last_of_run=%b",
					$realtime, out_byte, last_of_run);
		end else begin
			want = expected_bytes.pop_front();
			if (out_byte !== want.value || last_of_run !== want.last_flag) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp byte=%h last=%b got byte=%h last=%b",
						$realtime, want.value, want.last_flag, out_byte, last_of_run);
			end
		end
	endtask

	// both channels sampled at the edge, before the block's registers move
	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && data_ready)
				sanitize_word(data_byte, end_of_stream);
			if (result_valid && result_ready)
				check_result();
			if ((data_valid && data_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles == QUIET_LIMIT) begin
					$display("%0t: timeout, %0d words still expected",
						$realtime, expected_bytes.size());
					$display("FAIL utf8_stream_sanitizer");
					$finish;
				end
			end
		end
	end

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (calm) begin
			result_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 5);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eos);
		if (!calm && $urandom_range(0, 3) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (!data_ready);
		words_sent++;
	endtask

	// sequence of len bytes with a valid lead, cut after keep bytes, eos on word eos_at
	task automatic send_sequence(input logic [2:0] len, input int keep, input int eos_at);
		logic [7:0] lead;
		case (len)
			LEN_ONE:  lead = 8'($urandom_range(0, 127));
			LEN_TWO:  lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
			LEN_THR:  lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
			default:  lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
		endcase
		for (int k = 0; k < keep; k++)
			send_word(k == 0 ? lead : {CONT_TAG, 6'($urandom())}, k == eos_at);
	endtask

	task automatic test_ascii_extremes();
		send_word(8'h00, 1'b0);
		send_word(8'h7F, 1'b0);
	endtask

	task automatic test_dropped_bytes();
		send_word(8'h80, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hC0, 1'b0);
		send_word(8'hC1, 1'b0);
		send_word(8'hF5, 1'b0);
		send_word(8'hFF, 1'b0);
	endtask

	task automatic test_full_sequences();
		send_word(8'hC2, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hEF, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hF4, 1'b0);
		send_word(8'h8F, 1'b0);
		send_word(8'hBF, 1'b0);
		// eos on the completing word still lets the run out
		send_word(8'hBF, 1'b1);
	endtask

	task automatic test_interrupted_sequences();
		send_word(8'hE0, 1'b0);
		send_word(8'hA0, 1'b0);
		send_word(8'h41, 1'b0);
		// a bad lead kills the open sequence as well
		send_word(8'hC2, 1'b0);
		send_word(8'hC0, 1'b0);
	endtask

	task automatic test_end_of_stream();
		send_word(8'hF0, 1'b0);
		send_word(8'h90, 1'b1);
		send_word(8'h80, 1'b0);
	endtask

	task automatic test_random_stream(input int unsigned count);
		int unsigned stop;
		logic [2:0]  len;
		int          keep;
		int          eos_at;
		stop = words_sent + count;
		while (words_sent < stop) begin
			len = 3'($urandom_range(1, 4));
			case ($urandom_range(0, 9))
				8: begin
					send_word(8'($urandom()), $urandom_range(0, 15) == 0);
				end
				9: begin
					// may be truncated, either by eos or by whatever comes next
					keep = $urandom_range(1, len);
					eos_at = $urandom_range(0, 1) ? keep - 1 : -1;
					send_sequence(len, keep, eos_at);
				end
				default: begin
					eos_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
					send_sequence(len, len, eos_at);
				end
			endcase
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_extremes();
		test_dropped_bytes();
		test_full_sequences();
		test_interrupted_sequences();
		test_end_of_stream();
		test_random_stream(340);
		calm = 1'b1;
		test_random_stream(60);

		data_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS utf8_stream_sanitizer");
		else
			$display("FAIL utf8_stream_sanitizer");
		$finish;
	end

endmodule

@@ files.f @@
design/utss_pkg.sv
design/utss_front.sv
design/utss_fifo.sv
design/utss_back.sv
design/utf8_stream_sanitizer.sv
verif/tb_utf8_stream_sanitizer.sv
